[hdl/pdt_pkg.sv]
package pdt_pkg;

	localparam int SLOT_COUNT_DEF     = 16;
	localparam int VALUE_BITS_DEF     = 64;
	localparam int SLOT_W             = 4;
	localparam int EXPIRE_W           = 10;
	localparam int CHAN_W             = 8;
	localparam int FLAGS_W            = 8;
	localparam int AGE_W              = 10;
	localparam int INTERVAL_W         = 4;
	localparam int KIND_W             = 3;

	localparam logic [AGE_W-1:0]      AGE_ON_ALLOC       = AGE_W'(999);
	localparam logic [AGE_W-1:0]      AGE_MAX            = AGE_W'(1023);
	localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RESET = INTERVAL_W'(1);

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_PUBLISH = 1'b1;

	typedef enum logic [KIND_W-1:0] {
		KIND_SENT      = 3'd0,
		KIND_CULLED    = 3'd1,
		KIND_DEFERRED  = 3'd2,
		KIND_RELEASE   = 3'd3,
		KIND_TICK_DONE = 3'd4
	} kind_t;

	typedef struct packed {
		logic load;
		logic pub_exec;
		logic tick_rd;
		logic tick_exec;
		logic tick_done;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
		logic release_due;
		logic idx_last;
	} dp_status_t;

endpackage

[hdl/publish_dedup_throttle.sv]
// publish: the item is captured with its slot row read, then the result is registered once
//   the output side is free; the next item is taken after the return to idle
// tick: per slot a registered memory read, then an age update; then the done result and
//   the return to idle; a waiting release or done result that is stalled delays the tick
// reset: asynchronous, clears valid bits, pending marks and control; interval back to 1
module publish_dedup_throttle #(
	parameter int SLOT_COUNT = pdt_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_BITS = pdt_pkg::VALUE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [pdt_pkg::INTERVAL_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           operation,
	input  logic [pdt_pkg::SLOT_W-1:0]     slot,
	input  logic [pdt_pkg::EXPIRE_W-1:0]   expire_time,
	input  logic [pdt_pkg::CHAN_W-1:0]     channel,
	input  logic [VALUE_BITS-1:0]          value,
	input  logic [pdt_pkg::FLAGS_W-1:0]    flags,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [pdt_pkg::KIND_W-1:0]     kind,
	output logic [pdt_pkg::SLOT_W-1:0]     out_slot,
	output logic [pdt_pkg::CHAN_W-1:0]     out_channel,
	output logic [VALUE_BITS-1:0]          out_value,
	output logic [pdt_pkg::FLAGS_W-1:0]    out_flags,
	output logic                           last
);
	import pdt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	pdt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd)
	);

	pdt_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.slot        (slot),
		.expire_time (expire_time),
		.channel     (channel),
		.value       (value),
		.flags       (flags),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.out_slot    (out_slot),
		.out_channel (out_channel),
		.out_value   (out_value),
		.out_flags   (out_flags),
		.last        (last)
	);

`ifndef SYNTH
	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted while an item is in work");

	a_only_release_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (kind == KIND_RELEASE))
		else $error("non-final result is not a release");

	a_no_payload_without_send: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == KIND_CULLED || kind == KIND_DEFERRED
			|| kind == KIND_TICK_DONE))
		|-> (out_value == '0 && out_channel == '0 && out_flags == '0))
		else $error("payload on a result that sends nothing");
`endif

endmodule

[hdl/pdt_ctrl.sv]
module pdt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               operation,
	input  pdt_pkg::dp_status_t status,
	output logic               in_stall,
	output pdt_pkg::ctrl_cmd_t cmd
);
	import pdt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUB,
		ST_TICK_RD,
		ST_TICK_EX,
		ST_TICK_DONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.pub_exec  = (state_q == ST_PUB) && status.out_free;
		cmd.tick_rd   = (state_q == ST_TICK_RD);
		cmd.tick_exec = (state_q == ST_TICK_EX) && (!status.release_due || status.out_free);
		cmd.tick_done = (state_q == ST_TICK_DONE) && status.out_free;
	end

	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (operation == OP_PUBLISH) ? ST_PUB : ST_TICK_RD;
					end
				end
				ST_PUB: begin
					if (cmd.pub_exec) begin
						state_q <= ST_IDLE;
					end
				end
				ST_TICK_RD: begin
					state_q <= ST_TICK_EX;
				end
				ST_TICK_EX: begin
					if (cmd.tick_exec) begin
						state_q <= status.idx_last ? ST_TICK_DONE : ST_TICK_RD;
					end
				end
				ST_TICK_DONE: begin
					if (cmd.tick_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/pdt_datapath.sv]
module pdt_datapath #(
	parameter int SLOT_COUNT = pdt_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_BITS = pdt_pkg::VALUE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pdt_pkg::ctrl_cmd_t                 cmd,
	output pdt_pkg::dp_status_t                status,
	input  logic                               cfg_wr_en,
	input  logic [pdt_pkg::INTERVAL_W-1:0]     cfg_wr_data,
	input  logic [pdt_pkg::SLOT_W-1:0]         slot,
	input  logic [pdt_pkg::EXPIRE_W-1:0]       expire_time,
	input  logic [pdt_pkg::CHAN_W-1:0]         channel,
	input  logic [VALUE_BITS-1:0]              value,
	input  logic [pdt_pkg::FLAGS_W-1:0]        flags,
	input  logic                               out_stall,
	output logic                               out_valid,
	output logic [pdt_pkg::KIND_W-1:0]         kind,
	output logic [pdt_pkg::SLOT_W-1:0]         out_slot,
	output logic [pdt_pkg::CHAN_W-1:0]         out_channel,
	output logic [VALUE_BITS-1:0]              out_value,
	output logic [pdt_pkg::FLAGS_W-1:0]        out_flags,
	output logic                               last
);
	import pdt_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ROW_W = VALUE_BITS + CHAN_W + FLAGS_W + AGE_W;

	logic [INTERVAL_W-1:0] min_interval_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [EXPIRE_W-1:0]   expire_q;
	logic [CHAN_W-1:0]     chan_q;
	logic [VALUE_BITS-1:0] value_q;
	logic [FLAGS_W-1:0]    flags_q;
	logic [IDX_W-1:0]      idx_q;
	logic                  in_use_q  [SLOT_COUNT];
	logic                  pending_q [SLOT_COUNT];

	logic [ROW_W-1:0] mem [SLOT_COUNT];
	logic [ROW_W-1:0] rd_row_q;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	logic [VALUE_BITS-1:0] rd_value;
	logic [CHAN_W-1:0]     rd_chan;
	logic [FLAGS_W-1:0]    rd_flags;
	logic [AGE_W-1:0]      rd_age;

	logic                  in_range;
	logic [IDX_W-1:0]      pub_idx;
	logic                  eff_in_use;
	logic                  eff_pending;
	logic [VALUE_BITS-1:0] eff_value;
	logic [CHAN_W-1:0]     eff_chan;
	logic [FLAGS_W-1:0]    eff_flags;
	logic [AGE_W-1:0]      eff_age;
	logic                  cull;
	logic                  defer;

	logic             tick_used;
	logic [AGE_W-1:0] age_inc;
	logic             release_due;

	logic                  out_valid_q;
	logic                  emit;
	kind_t                 kind_d, kind_q;
	logic [SLOT_W-1:0]     slot_d, out_slot_q;
	logic [CHAN_W-1:0]     chan_d, out_chan_q;
	logic [VALUE_BITS-1:0] value_d, out_value_q;
	logic [FLAGS_W-1:0]    flags_d, out_flags_q;
	logic                  last_d, last_q;

	// configuration and captured request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= MIN_INTERVAL_RESET;
		end else if (cfg_wr_en) begin
			min_interval_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			slot_q   <= slot;
			expire_q <= expire_time;
			chan_q   <= channel;
			value_q  <= value;
			flags_q  <= flags;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= '0;
		end else if (cmd.tick_exec) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// slot memory
	assign rd_addr = cmd.load ? IDX_W'(slot) : idx_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.load || cmd.tick_rd) begin
			rd_row_q <= mem[rd_addr];
		end
	end

	assign {rd_value, rd_chan, rd_flags, rd_age} = rd_row_q;

	// publish evaluation
	assign in_range    = (int'(slot_q) < SLOT_COUNT);
	assign pub_idx     = IDX_W'(slot_q);
	assign eff_in_use  = in_range && in_use_q[pub_idx];
	assign eff_pending = eff_in_use && pending_q[pub_idx];
	assign eff_value   = eff_in_use ? rd_value : '0;
	assign eff_chan    = eff_in_use ? rd_chan  : '0;
	assign eff_flags   = eff_in_use ? rd_flags : '0;
	assign eff_age     = eff_in_use ? rd_age   : AGE_ON_ALLOC;
	assign cull        = (eff_value == value_q) && (AGE_W'(expire_q) > eff_age);
	assign defer       = (AGE_W'(min_interval_q) >= eff_age);

	// tick evaluation
	assign tick_used   = in_use_q[idx_q];
	assign age_inc     = (rd_age == AGE_MAX) ? rd_age : rd_age + AGE_W'(1);
	assign release_due = tick_used && pending_q[idx_q] && (age_inc > AGE_W'(min_interval_q));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = {rd_value, rd_chan, rd_flags, release_due ? AGE_W'(0) : age_inc};
		if (cmd.pub_exec && in_range) begin
			mem_we    = 1'b1;
			mem_waddr = pub_idx;
			priority if (cull) begin
				mem_wdata = {eff_value, eff_chan, eff_flags, eff_age};
			end else if (defer) begin
				mem_wdata = {value_q, chan_q, flags_q, eff_age};
			end else begin
				mem_wdata = {value_q, eff_chan, eff_flags, AGE_W'(0)};
			end
		end else if (cmd.tick_exec && tick_used) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				in_use_q[i]  <= 1'b0;
				pending_q[i] <= 1'b0;
			end
		end else if (cmd.pub_exec && in_range) begin
			in_use_q[pub_idx]  <= 1'b1;
			pending_q[pub_idx] <= cull ? eff_pending : defer;
		end else if (cmd.tick_exec && release_due) begin
			pending_q[idx_q] <= 1'b0;
		end
	end

	// result register
	always_comb begin
		emit    = 1'b0;
		kind_d  = KIND_TICK_DONE;
		slot_d  = '0;
		chan_d  = '0;
		value_d = '0;
		flags_d = '0;
		last_d  = 1'b1;
		if (cmd.pub_exec) begin
			emit   = 1'b1;
			slot_d = slot_q;
			priority if (!in_range) begin
				kind_d  = KIND_SENT;
				chan_d  = chan_q;
				value_d = value_q;
				flags_d = flags_q;
			end else if (cull) begin
				kind_d = KIND_CULLED;
			end else if (defer) begin
				kind_d = KIND_DEFERRED;
			end else begin
				kind_d  = KIND_SENT;
				chan_d  = chan_q;
				value_d = value_q;
				flags_d = flags_q;
			end
		end else if (cmd.tick_exec && release_due) begin
			emit    = 1'b1;
			kind_d  = KIND_RELEASE;
			slot_d  = SLOT_W'(idx_q);
			chan_d  = rd_chan;
			value_d = rd_value;
			flags_d = rd_flags;
			last_d  = 1'b0;
		end else if (cmd.tick_done) begin
			emit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q      <= kind_d;
			out_slot_q  <= slot_d;
			out_chan_q  <= chan_d;
			out_value_q <= value_d;
			out_flags_q <= flags_d;
			last_q      <= last_d;
		end
	end

	assign status.out_free    = !out_valid_q || !out_stall;
	assign status.release_due = release_due;
	assign status.idx_last    = (idx_q == IDX_W'(SLOT_COUNT - 1));

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_slot    = out_slot_q;
	assign out_channel = out_chan_q;
	assign out_value   = out_value_q;
	assign out_flags   = out_flags_q;
	assign last        = last_q;

endmodule
